/* src/odtc_pkg.sv */
`timescale 1ns / 1ps

package odtc_pkg;

    // Gain table geometry: the table always has 16 rows, the parameter picks how many are live
    localparam int TABLE_ROWS = 16;
    localparam int INDEX_W    = 4;
    localparam int DAC_W      = 12;
    localparam int GAIN_W     = 7;
    localparam int BACKOFF_W  = 10;
    localparam int TIME_W     = 32;
    localparam int ERR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COARSE_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_RELOAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_HIGH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP      = 3'd6;

    // Register reset values
    localparam logic [DAC_W-1:0]     RST_COARSE_START   = 12'd2048;
    localparam logic [TIME_W-1:0]    RST_QUIET_LIMIT    = 32'd300000;
    localparam logic [BACKOFF_W-1:0] RST_BACKOFF_RELOAD = 10'd999;
    localparam logic [BACKOFF_W-1:0] RST_FINE_GAIN      = 10'd333;
    localparam logic [DAC_W-1:0]     RST_FINE_LOW       = 12'd500;
    localparam logic [DAC_W-1:0]     RST_FINE_HIGH      = 12'd3595;
    localparam logic [DAC_W-1:0]     RST_HALF_STEP      = 12'd500;

    // State reset values
    localparam logic [GAIN_W-1:0]    RST_GAIN    = 7'd5;
    localparam logic [INDEX_W-1:0]   RST_INDEX   = 4'd1;
    localparam logic [BACKOFF_W-1:0] RST_BACKOFF = 10'd7;

    // Lock lamp codes
    localparam logic [1:0] LAMP_TRACK  = 2'd0;
    localparam logic [1:0] LAMP_NEAR   = 2'd1;
    localparam logic [1:0] LAMP_UNLOCK = 2'd2;

    localparam logic [DAC_W-1:0] DAC_MAX = 12'd4095;

    // Seconds thresholds and step multipliers
    localparam logic [14:0] GAIN_SECS [TABLE_ROWS] = '{
        15'd1, 15'd2, 15'd5, 15'd10, 15'd19, 15'd33, 15'd59, 15'd154,
        15'd240, 15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd32767,
        15'd32767, 15'd32767
    };
    localparam logic [GAIN_W-1:0] GAIN_MULT [TABLE_ROWS] = '{
        7'd70, 7'd70, 7'd65, 7'd55, 7'd40, 7'd11, 7'd5, 7'd3,
        7'd2, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1
    };

    typedef struct packed {
        logic [TIME_W-1:0]    quiet_limit_s;
        logic [BACKOFF_W-1:0] backoff_reload;
        logic [BACKOFF_W-1:0] fine_gain;
        logic [DAC_W-1:0]     fine_low;
        logic [DAC_W-1:0]     fine_high;
        logic [DAC_W-1:0]     half_step;
    } cfg_t;

    typedef struct packed {
        logic [DAC_W-1:0]  coarse_dac;
        logic [DAC_W-1:0]  fine_dac;
        logic              coarse_written;
        logic              fine_written;
        logic              reset_request;
        logic [1:0]        lock_status;
        logic [GAIN_W-1:0] gain_now;
    } result_t;

    // Lamp from a small-error flag and the gain in use
    function automatic logic [1:0] lamp_of(input logic small_err, input logic [GAIN_W-1:0] gain);
        logic [1:0] lamp;
        lamp = LAMP_UNLOCK;
        if (small_err && gain == 7'd2) lamp = LAMP_NEAR;
        else if (small_err && gain == 7'd1) lamp = LAMP_TRACK;
        return lamp;
    endfunction

endpackage

/* src/oscillator_dac_tracking_control.sv */
`timescale 1ns / 1ps
// Channel   | Beat                                          | Handshake
// ----------+-----------------------------------------------+----------------------
// s_        | count_error, now_seconds                      | s_valid / s_ready
// m_        | coarse/fine DAC, written flags, reset, lamp, gain | m_valid / m_ready
// cfg_      | cfg_index, cfg_data                           | cfg_valid / cfg_ready
//
// One beat per cycle sustained while m_ready is high. A beat is held in the input
// register; the update is combinational from there into the result register, and
// state registers load with the result register, which sets the rate.
// Reset (aresetn low, synchronous) loads register defaults and the initial state.
// A stalled m_ stage holds its beat; the input register still takes one more beat.
// cfg_ready is always high; writes are expected only while the block is idle.

module oscillator_dac_tracking_control #(
    parameter int GAIN_STEPS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [odtc_pkg::ERR_W-1:0]    s_count_error,
    input  logic [odtc_pkg::TIME_W-1:0]          s_now_seconds,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [odtc_pkg::DAC_W-1:0]           m_coarse_dac,
    output logic [odtc_pkg::DAC_W-1:0]           m_fine_dac,
    output logic                                 m_coarse_written,
    output logic                                 m_fine_written,
    output logic                                 m_reset_request,
    output logic [1:0]                           m_lock_status,
    output logic [odtc_pkg::GAIN_W-1:0]          m_gain_now,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [odtc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [odtc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    odtc_pkg::cfg_t    cfg_reg;
    odtc_pkg::result_t res;
    odtc_pkg::result_t m_res_reg;

    logic                                 in_valid_reg;
    logic signed [odtc_pkg::ERR_W-1:0]    in_err_reg;
    logic [odtc_pkg::TIME_W-1:0]          in_now_reg;
    logic                                 m_valid_reg;
    logic                                 step_en;
    logic                                 cfg_wr;
    logic                                 coarse_load;

    assign cfg_ready   = 1'b1;
    assign cfg_wr      = cfg_valid && cfg_ready;
    assign coarse_load = cfg_wr && (cfg_index == odtc_pkg::REG_COARSE_START);

    // Fire the update when the result register is free or being drained
    assign step_en = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quiet_limit_s  <= odtc_pkg::RST_QUIET_LIMIT;
            cfg_reg.backoff_reload <= odtc_pkg::RST_BACKOFF_RELOAD;
            cfg_reg.fine_gain      <= odtc_pkg::RST_FINE_GAIN;
            cfg_reg.fine_low       <= odtc_pkg::RST_FINE_LOW;
            cfg_reg.fine_high      <= odtc_pkg::RST_FINE_HIGH;
            cfg_reg.half_step      <= odtc_pkg::RST_HALF_STEP;
        end else if (cfg_wr) begin
            case (cfg_index)
                odtc_pkg::REG_QUIET_LIMIT:    cfg_reg.quiet_limit_s  <= cfg_data;
                odtc_pkg::REG_BACKOFF_RELOAD: cfg_reg.backoff_reload <= cfg_data[9:0];
                odtc_pkg::REG_FINE_GAIN:      cfg_reg.fine_gain      <= cfg_data[9:0];
                odtc_pkg::REG_FINE_LOW:       cfg_reg.fine_low       <= cfg_data[11:0];
                odtc_pkg::REG_FINE_HIGH:      cfg_reg.fine_high      <= cfg_data[11:0];
                odtc_pkg::REG_HALF_STEP:      cfg_reg.half_step      <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_err_reg <= s_count_error;
            in_now_reg <= s_now_seconds;
        end
    end

    odtc_core #(
        .GAIN_STEPS(GAIN_STEPS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .coarse_load      (coarse_load),
        .coarse_load_value(cfg_data[11:0]),
        .step_en          (step_en),
        .count_error      (in_err_reg),
        .now_seconds      (in_now_reg),
        .res              (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_res_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_coarse_dac     = m_res_reg.coarse_dac;
    assign m_fine_dac       = m_res_reg.fine_dac;
    assign m_coarse_written = m_res_reg.coarse_written;
    assign m_fine_written   = m_res_reg.fine_written;
    assign m_reset_request  = m_res_reg.reset_request;
    assign m_lock_status    = m_res_reg.lock_status;
    assign m_gain_now       = m_res_reg.gain_now;

`ifndef SYNTHESIS
    a_coarse_requests_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_coarse_written) |-> m_reset_request)
        else $error("coarse correction without reset request");

    a_written_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_coarse_written && m_fine_written))
        else $error("coarse and fine written flags both set");

    a_gain_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gain_now != 7'd0))
        else $error("zero gain in result");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room downstream");

    a_step_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_valid)
        else $error("update fired without a result beat");
`endif

endmodule

/* src/odtc_gain_select.sv */
`timescale 1ns / 1ps

module odtc_gain_select #(
    parameter int GAIN_STEPS = 10
) (
    input  logic [odtc_pkg::TIME_W-1:0]  elapsed,
    input  logic [odtc_pkg::INDEX_W-1:0] prev_index,
    input  logic                         err_le2,
    output logic [odtc_pkg::GAIN_W-1:0]  gain,
    output logic [odtc_pkg::INDEX_W-1:0] index,
    output logic                         sticky
);

    localparam logic [odtc_pkg::INDEX_W-1:0] LAST = odtc_pkg::INDEX_W'(GAIN_STEPS - 1);

    logic [odtc_pkg::INDEX_W-1:0] hit;
    logic                         above_floor;

    // First live row whose threshold exceeds the elapsed time, else the last row
    always_comb begin
        hit = LAST;
        for (int k = odtc_pkg::TABLE_ROWS - 1; k >= 0; k--) begin
            if (k < GAIN_STEPS - 1 && {17'd0, odtc_pkg::GAIN_SECS[k]} > elapsed) begin
                hit = odtc_pkg::INDEX_W'(k);
            end
        end
    end

    // Slow gains stick unless the error is large and positive
    assign above_floor = (GAIN_STEPS >= 3) && (32'(prev_index) > 32'(GAIN_STEPS - 3));
    assign sticky      = (prev_index > hit) && above_floor && err_le2;
    assign index       = hit;
    assign gain        = sticky ? odtc_pkg::GAIN_MULT[prev_index] : odtc_pkg::GAIN_MULT[hit];

endmodule

/* src/odtc_core.sv */
`timescale 1ns / 1ps

module odtc_core #(
    parameter int GAIN_STEPS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  odtc_pkg::cfg_t                 cfg,
    input  logic                           coarse_load,
    input  logic [odtc_pkg::DAC_W-1:0]     coarse_load_value,
    input  logic                           step_en,
    input  logic signed [odtc_pkg::ERR_W-1:0] count_error,
    input  logic [odtc_pkg::TIME_W-1:0]    now_seconds,
    output odtc_pkg::result_t              res
);

    localparam logic [odtc_pkg::INDEX_W-1:0] LAST = odtc_pkg::INDEX_W'(GAIN_STEPS - 1);

    logic [odtc_pkg::DAC_W-1:0]     coarse_reg, coarse_next;
    logic [odtc_pkg::DAC_W-1:0]     fine_reg, fine_next;
    logic [odtc_pkg::GAIN_W-1:0]    gain_reg, gain_next;
    logic [odtc_pkg::INDEX_W-1:0]   index_reg, index_next;
    logic [odtc_pkg::BACKOFF_W-1:0] backoff_reg, backoff_next;
    logic [odtc_pkg::TIME_W-1:0]    last_fix_reg, last_fix_next;
    logic [1:0]                     lamp_reg, lamp_next;

    logic                           fine_mode;
    logic [odtc_pkg::TIME_W-1:0]    elapsed;

    // Fine path
    logic signed [2:0]  e_small;
    logic signed [13:0] fine_prod;
    logic signed [15:0] fine_sum;
    logic signed [15:0] avg;
    logic [odtc_pkg::DAC_W-1:0] avg_sat;
    logic               avg_hi, avg_lo;

    // Coarse path
    logic signed [16:0] e_adj;
    logic signed [16:0] e_quot;
    logic signed [13:0] q;
    logic [13:0]        mag;
    logic [20:0]        step;
    logic [13:0]        step_cl;
    logic signed [15:0] nc;
    logic [odtc_pkg::DAC_W-1:0] nc_cl;
    logic signed [13:0] nf;
    logic               err_le2, err_small;

    logic [odtc_pkg::GAIN_W-1:0]  sel_gain;
    logic [odtc_pkg::INDEX_W-1:0] sel_index;
    logic                         sel_sticky;

    assign elapsed = now_seconds - last_fix_reg;
    assign fine_mode = (count_error > -16'sd4) && (count_error < 16'sd4) && (gain_reg <= 7'd1);

    // Fine target average, truncated toward zero
    assign e_small   = count_error[2:0];
    assign fine_prod = 14'(e_small) * 14'($signed({1'b0, cfg.fine_gain}));
    assign fine_sum  = $signed({4'd0, coarse_reg}) + {{2{fine_prod[13]}}, fine_prod}
                     + $signed({4'd0, fine_reg});
    assign avg       = (fine_sum + $signed({15'd0, fine_sum[15]})) >>> 1;
    assign avg_sat   = avg[15] ? '0 : (avg > 16'sd4095 ? odtc_pkg::DAC_MAX : avg[11:0]);
    assign avg_hi    = avg > $signed({4'd0, cfg.fine_high});
    assign avg_lo    = avg < $signed({4'd0, cfg.fine_low});

    // Coarse error: divide by four toward zero
    assign e_adj   = {count_error[15], count_error} + (count_error[15] ? 17'sd3 : 17'sd0);
    assign e_quot  = e_adj >>> 2;
    assign q       = e_quot[13:0];
    assign mag     = q[13] ? 14'(-q) : q;
    assign err_le2 = q <= 14'sd2;
    assign err_small = (q >= -14'sd1) && (q <= 14'sd1);

    odtc_gain_select #(
        .GAIN_STEPS(GAIN_STEPS)
    ) u_gain_select (
        .elapsed   (elapsed),
        .prev_index(index_reg),
        .err_le2   (err_le2),
        .gain      (sel_gain),
        .index     (sel_index),
        .sticky    (sel_sticky)
    );

    // Coarse step, clamped to the DAC range
    assign step    = 21'(mag) * 21'(sel_gain);
    assign step_cl = (step > 21'd8192) ? 14'd8192 : step[13:0];
    assign nc      = q[13] ? $signed({4'd0, coarse_reg}) - $signed({2'd0, step_cl})
                           : $signed({4'd0, coarse_reg}) + $signed({2'd0, step_cl});
    assign nc_cl   = nc[15] ? '0 : (nc > 16'sd4095 ? odtc_pkg::DAC_MAX : nc[11:0]);

    // Half-step compensation for a single coarse step
    assign nf = q[13] ? $signed({2'd0, fine_reg}) + $signed({2'd0, cfg.half_step})
                      : $signed({2'd0, fine_reg}) - $signed({2'd0, cfg.half_step});

    // State update and result
    always_comb begin
        coarse_next   = coarse_reg;
        fine_next     = fine_reg;
        gain_next     = gain_reg;
        index_next    = index_reg;
        backoff_next  = backoff_reg;
        last_fix_next = last_fix_reg;
        lamp_next     = lamp_reg;
        res.coarse_written = 1'b0;
        res.fine_written   = 1'b0;
        res.reset_request  = 1'b0;
        if (fine_mode) begin
            if (count_error != 16'sd0) begin
                fine_next = avg_sat;
                res.fine_written = (avg_sat != fine_reg);
                if (backoff_reg == '0 || avg_hi || avg_lo) begin
                    res.reset_request = 1'b1;
                    backoff_next = cfg.backoff_reload;
                end else begin
                    backoff_next = backoff_reg - 10'd1;
                end
            end
        end else if (q != 14'sd0) begin
            gain_next = sel_gain;
            if (!sel_sticky) index_next = sel_index;
            coarse_next = nc_cl;
            if (step == 21'd1) begin
                fine_next = (nf < 14'sd0 || nf > 14'sd4095) ? nc_cl : nf[11:0];
            end else begin
                fine_next = nc_cl;
            end
            lamp_next     = odtc_pkg::lamp_of(err_small, sel_gain);
            last_fix_next = now_seconds;
            backoff_next  = cfg.backoff_reload;
            res.coarse_written = 1'b1;
            res.reset_request  = 1'b1;
        end else begin
            if (elapsed > cfg.quiet_limit_s) begin
                gain_next  = 7'd1;
                index_next = LAST;
            end
            lamp_next = odtc_pkg::lamp_of(1'b1, gain_next);
        end
        res.coarse_dac  = coarse_next;
        res.fine_dac    = fine_next;
        res.lock_status = lamp_next;
        res.gain_now    = gain_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coarse_reg   <= odtc_pkg::RST_COARSE_START;
            fine_reg     <= '0;
            gain_reg     <= odtc_pkg::RST_GAIN;
            index_reg    <= odtc_pkg::RST_INDEX;
            backoff_reg  <= odtc_pkg::RST_BACKOFF;
            last_fix_reg <= '0;
            lamp_reg     <= odtc_pkg::LAMP_UNLOCK;
        end else if (coarse_load) begin
            coarse_reg <= coarse_load_value;
        end else if (step_en) begin
            coarse_reg   <= coarse_next;
            fine_reg     <= fine_next;
            gain_reg     <= gain_next;
            index_reg    <= index_next;
            backoff_reg  <= backoff_next;
            last_fix_reg <= last_fix_next;
            lamp_reg     <= lamp_next;
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int STEPS           = 10;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASES          = 6;
    localparam int BEATS_PER_PHASE = 64;

    // One stimulus row: payload plus an optional hand-typed result
    typedef struct packed {
        logic signed [odtc_pkg::ERR_W-1:0] err;
        logic [odtc_pkg::TIME_W-1:0]       stamp;
        logic                              pinned;
        odtc_pkg::result_t                 want;
    } probe_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [odtc_pkg::ERR_W-1:0] s_count_error;
    logic [odtc_pkg::TIME_W-1:0]       s_now_seconds;
    logic                              m_valid;
    logic                              m_ready;
    logic [odtc_pkg::DAC_W-1:0]        m_coarse_dac;
    logic [odtc_pkg::DAC_W-1:0]        m_fine_dac;
    logic                              m_coarse_written;
    logic                              m_fine_written;
    logic                              m_reset_request;
    logic [1:0]                        m_lock_status;
    logic [odtc_pkg::GAIN_W-1:0]       m_gain_now;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [odtc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [odtc_pkg::CFG_DATA_W-1:0]   cfg_data;

    oscillator_dac_tracking_control #(
        .GAIN_STEPS(STEPS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_count_error   (s_count_error),
        .s_now_seconds   (s_now_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_coarse_dac    (m_coarse_dac),
        .m_fine_dac      (m_fine_dac),
        .m_coarse_written(m_coarse_written),
        .m_fine_written  (m_fine_written),
        .m_reset_request (m_reset_request),
        .m_lock_status   (m_lock_status),
        .m_gain_now      (m_gain_now),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Register copy
    logic [odtc_pkg::DAC_W-1:0]     coarse_start_c;
    logic [odtc_pkg::TIME_W-1:0]    quiet_limit_c;
    logic [odtc_pkg::BACKOFF_W-1:0] backoff_reload_c;
    logic [odtc_pkg::BACKOFF_W-1:0] fine_gain_c;
    logic [odtc_pkg::DAC_W-1:0]     fine_low_c;
    logic [odtc_pkg::DAC_W-1:0]     fine_high_c;
    logic [odtc_pkg::DAC_W-1:0]     half_step_c;

    // Loop state copy
    logic [odtc_pkg::DAC_W-1:0]     coarse_m;
    logic [odtc_pkg::DAC_W-1:0]     fine_m;
    logic [odtc_pkg::GAIN_W-1:0]    gain_m;
    logic [odtc_pkg::INDEX_W-1:0]   gidx_m;
    logic [odtc_pkg::BACKOFF_W-1:0] backoff_m;
    logic [odtc_pkg::TIME_W-1:0]    last_fix_m;
    logic [1:0]                     lamp_m;

    odtc_pkg::result_t dac_expect_q[$];
    probe_t            pin_q[$];
    probe_t            plan_q[$];

    bit steady_flow;
    int mismatches;
    int beats_in, beats_out, reg_writes;
    int coarse_fixes, fine_moves, counter_resets;

    function automatic odtc_pkg::result_t mk_result(input int c, input int f, input bit cw,
                                                    input bit fw, input bit rr,
                                                    input logic [1:0] lamp, input int g);
        odtc_pkg::result_t r;
        r.coarse_dac     = odtc_pkg::DAC_W'(c);
        r.fine_dac       = odtc_pkg::DAC_W'(f);
        r.coarse_written = cw;
        r.fine_written   = fw;
        r.reset_request  = rr;
        r.lock_status    = lamp;
        r.gain_now       = odtc_pkg::GAIN_W'(g);
        return r;
    endfunction

    function automatic logic [1:0] lamp_code(input int q, input logic [odtc_pkg::GAIN_W-1:0] g);
        if (q >= -1 && q <= 1 && g == 7'd2) return odtc_pkg::LAMP_NEAR;
        if (q >= -1 && q <= 1 && g == 7'd1) return odtc_pkg::LAMP_TRACK;
        return odtc_pkg::LAMP_UNLOCK;
    endfunction

    task automatic reset_loop_model();
        coarse_start_c   = odtc_pkg::RST_COARSE_START;
        quiet_limit_c    = odtc_pkg::RST_QUIET_LIMIT;
        backoff_reload_c = odtc_pkg::RST_BACKOFF_RELOAD;
        fine_gain_c      = odtc_pkg::RST_FINE_GAIN;
        fine_low_c       = odtc_pkg::RST_FINE_LOW;
        fine_high_c      = odtc_pkg::RST_FINE_HIGH;
        half_step_c      = odtc_pkg::RST_HALF_STEP;
        coarse_m   = odtc_pkg::RST_COARSE_START;
        fine_m     = '0;
        gain_m     = odtc_pkg::RST_GAIN;
        gidx_m     = odtc_pkg::RST_INDEX;
        backoff_m  = odtc_pkg::RST_BACKOFF;
        last_fix_m = '0;
        lamp_m     = odtc_pkg::LAMP_UNLOCK;
    endtask

    task automatic apply_reg(input logic [odtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [odtc_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            odtc_pkg::REG_COARSE_START: begin
                coarse_start_c = d[odtc_pkg::DAC_W-1:0];
                coarse_m       = d[odtc_pkg::DAC_W-1:0];
            end
            odtc_pkg::REG_QUIET_LIMIT:    quiet_limit_c    = d;
            odtc_pkg::REG_BACKOFF_RELOAD: backoff_reload_c = d[odtc_pkg::BACKOFF_W-1:0];
            odtc_pkg::REG_FINE_GAIN:      fine_gain_c      = d[odtc_pkg::BACKOFF_W-1:0];
            odtc_pkg::REG_FINE_LOW:       fine_low_c       = d[odtc_pkg::DAC_W-1:0];
            odtc_pkg::REG_FINE_HIGH:      fine_high_c      = d[odtc_pkg::DAC_W-1:0];
            odtc_pkg::REG_HALF_STEP:      half_step_c      = d[odtc_pkg::DAC_W-1:0];
            default: ;
        endcase
    endtask

    // One control-loop update: fine averaging or coarse stepping
    task automatic steer_dacs(input logic signed [odtc_pkg::ERR_W-1:0] raw_err,
                              input logic [odtc_pkg::TIME_W-1:0] stamp,
                              output odtc_pkg::result_t res);
        int e, q, target, avg, sat, nc, nf, mag, stp, lim, pick, prev;
        logic [odtc_pkg::TIME_W-1:0] elapsed;
        logic cw, fw, rr;
        e  = int'(raw_err);
        cw = 1'b0;
        fw = 1'b0;
        rr = 1'b0;
        if (e > -4 && e < 4 && gain_m <= 1) begin
            // fine mode; a zero error leaves everything alone
            if (e != 0) begin
                target = int'(coarse_m) + e * int'(fine_gain_c);
                avg    = (target + int'(fine_m)) / 2;
                sat    = avg < 0 ? 0 : (avg > 4095 ? 4095 : avg);
                if (sat != int'(fine_m)) begin
                    fine_m = odtc_pkg::DAC_W'(sat);
                    fw     = 1'b1;
                end
                if (backoff_m == 0 || avg > int'(fine_high_c) || avg < int'(fine_low_c)) begin
                    rr        = 1'b1;
                    backoff_m = backoff_reload_c;
                end else begin
                    backoff_m = odtc_pkg::BACKOFF_W'(int'(backoff_m) - 1);
                end
            end
        end else begin
            q       = e / 4;
            elapsed = stamp - last_fix_m;
            if (q != 0) begin
                mag  = q < 0 ? -q : q;
                pick = 0;
                while (pick < STEPS - 1 && !(odtc_pkg::GAIN_SECS[pick] > elapsed)) pick++;
                prev   = int'(gidx_m);
                gain_m = odtc_pkg::GAIN_MULT[pick];
                // keep a slow gain for small corrections
                if (prev > pick && prev > STEPS - 3 && q <= 2) gain_m = odtc_pkg::GAIN_MULT[prev];
                else gidx_m = odtc_pkg::INDEX_W'(pick);
                stp = mag * int'(gain_m);
                lim = stp > 8192 ? 8192 : stp;
                nc  = q < 0 ? int'(coarse_m) - lim : int'(coarse_m) + lim;
                coarse_m = odtc_pkg::DAC_W'(nc < 0 ? 0 : (nc > 4095 ? 4095 : nc));
                if (stp == 1) begin
                    nf = int'(fine_m) + (q < 0 ? int'(half_step_c) : -int'(half_step_c));
                    fine_m = (nf < 0 || nf > 4095) ? coarse_m : odtc_pkg::DAC_W'(nf);
                end else begin
                    fine_m = coarse_m;
                end
                lamp_m     = lamp_code(q, gain_m);
                last_fix_m = stamp;
                backoff_m  = backoff_reload_c;
                cw = 1'b1;
                rr = 1'b1;
            end else begin
                if (elapsed > quiet_limit_c) begin
                    gain_m = 7'd1;
                    gidx_m = odtc_pkg::INDEX_W'(STEPS - 1);
                end
                lamp_m = lamp_code(0, gain_m);
            end
        end
        res = mk_result(int'(coarse_m), int'(fine_m), cw, fw, rr, lamp_m, int'(gain_m));
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Monitor: check result beats, predict on input beats, track register writes
    odtc_pkg::result_t predicted, oldest;
    probe_t            pin;
    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_loop_model();
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                coarse_fixes   += int'(m_coarse_written);
                fine_moves     += int'(m_fine_written);
                counter_resets += int'(m_reset_request);
                if (dac_expect_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat mismatch, expected none, got coarse_dac %0d",
                             $time, m_coarse_dac);
                end else begin
                    oldest = dac_expect_q.pop_front();
                    check_field("coarse_dac", 32'(oldest.coarse_dac), 32'(m_coarse_dac));
                    check_field("fine_dac", 32'(oldest.fine_dac), 32'(m_fine_dac));
                    check_field("coarse_written", 32'(oldest.coarse_written),
                                32'(m_coarse_written));
                    check_field("fine_written", 32'(oldest.fine_written), 32'(m_fine_written));
                    check_field("reset_request", 32'(oldest.reset_request),
                                32'(m_reset_request));
                    check_field("lock_status", 32'(oldest.lock_status), 32'(m_lock_status));
                    check_field("gain_now", 32'(oldest.gain_now), 32'(m_gain_now));
                end
            end
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                apply_reg(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                beats_in++;
                steer_dacs(s_count_error, s_now_seconds, predicted);
                pin = pin_q.size() != 0 ? pin_q.pop_front() : '0;
                dac_expect_q.push_back(pin.pinned ? pin.want : predicted);
            end
        end
    end

    // Watchdog on cycles with no beat anywhere
    int stuck_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, stuck_cycles, dac_expect_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Result side backpressure: mostly short stalls, a few long ones
    initial begin
        int hold, r;
        bit on;
        m_ready = 1'b1;
        hold    = 0;
        on      = 1'b1;
        forever begin
            @(negedge aclk);
            if (steady_flow) begin
                m_ready = 1'b1;
                hold    = 0;
            end else begin
                if (hold == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 55) begin
                        on = 1'b1; hold = $urandom_range(1, 8);
                    end else if (r < 85) begin
                        on = 1'b0; hold = $urandom_range(1, 3);
                    end else if (r < 96) begin
                        on = 1'b0; hold = $urandom_range(4, 12);
                    end else begin
                        on = 1'b0; hold = $urandom_range(20, 60);
                    end
                end
                m_ready = on;
                hold--;
            end
        end
    end

    // Drive one input beat after a random gap and wait for it to be taken
    task automatic send_beat(input probe_t p);
        int gap, r;
        @(negedge aclk);
        r   = $urandom_range(0, 99);
        gap = steady_flow ? 0 : (r < 60 ? 0 : (r < 85 ? $urandom_range(1, 3) :
              (r < 96 ? $urandom_range(4, 10) : $urandom_range(20, 40))));
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        pin_q.push_back(p);
        s_count_error = p.err;
        s_now_seconds = p.stamp;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [odtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [odtc_pkg::CFG_DATA_W-1:0] d);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = d;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic add_row(input int e, input logic [odtc_pkg::TIME_W-1:0] stamp,
                           input bit pinned, input odtc_pkg::result_t want);
        probe_t p;
        p.err    = odtc_pkg::ERR_W'(e);
        p.stamp  = stamp;
        p.pinned = pinned;
        p.want   = want;
        plan_q.push_back(p);
    endtask

    initial begin
        probe_t p;
        int phase, n, r, k;
        logic [odtc_pkg::TIME_W-1:0] stamp_s;
        s_valid       = 1'b0;
        s_count_error = '0;
        s_now_seconds = '0;
        cfg_valid     = 1'b0;
        cfg_index     = odtc_pkg::REG_COARSE_START;
        cfg_data      = '0;
        steady_flow   = 1'b0;
        mismatches    = 0;
        aresetn       = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows: reset state, error extremes, quiet drop, then the fine/coarse corners
        add_row(0,      32'd100,    1, mk_result(2048, 0, 0, 0, 0, odtc_pkg::LAMP_UNLOCK, 5));
        add_row(32767,  32'd100,    1, mk_result(4095, 4095, 1, 0, 1, odtc_pkg::LAMP_UNLOCK, 3));
        add_row(-32768, 32'd100,    1, mk_result(0, 0, 1, 0, 1, odtc_pkg::LAMP_UNLOCK, 70));
        add_row(0,      32'd300101, 1, mk_result(0, 0, 0, 0, 0, odtc_pkg::LAMP_TRACK, 1));
        add_row(0,      32'd300101, 1, mk_result(0, 0, 0, 0, 0, odtc_pkg::LAMP_TRACK, 1));
        add_row(3,      32'd300101, 0, '0);   // fine mode, average below fine_low
        add_row(-3,     32'd300101, 0, '0);   // average goes negative, saturates
        add_row(1,      32'd300101, 0, '0);
        add_row(-1,     32'd300101, 0, '0);
        add_row(2,      32'd300101, 0, '0);
        add_row(-2,     32'd300101, 0, '0);
        add_row(4,      32'd300102, 0, '0);   // table miss, single step compensation
        add_row(-4,     32'd300103, 0, '0);   // slow gain kept, compensation other way
        add_row(8,      32'd300104, 0, '0);   // slow gain kept, double step
        add_row(12,     32'd300110, 0, '0);   // too large to keep slow gain
        add_row(-7,     32'd300111, 0, '0);   // divide truncates toward zero
        add_row(2,      32'd300112, 0, '0);   // small error at high gain: zero coarse error
        add_row(-3,     32'd300112, 0, '0);
        add_row(5,      32'd300500, 0, '0);
        add_row(0,      32'hFFFF_FFFF, 0, '0);
        add_row(-5,     32'd0,      0, '0);   // elapsed time wraps
        add_row(3,      32'd1,      0, '0);
        add_row(32767,  32'd2,      0, '0);
        add_row(-1,     32'd3,      0, '0);
        for (k = 0; k < plan_q.size(); k++) send_beat(plan_q[k]);
        stamp_s = 32'd3;

        // Random beats over several register settings
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                while (dac_expect_q.size() != 0) @(posedge aclk);
                repeat (4) @(posedge aclk);
                case (phase)
                    1: begin
                        write_reg(odtc_pkg::REG_COARSE_START, 32'd0);
                        write_reg(odtc_pkg::REG_QUIET_LIMIT, 32'd0);
                        write_reg(odtc_pkg::REG_BACKOFF_RELOAD, 32'd0);
                        write_reg(odtc_pkg::REG_FINE_GAIN, 32'd0);
                        write_reg(odtc_pkg::REG_FINE_LOW, 32'd0);
                        write_reg(odtc_pkg::REG_FINE_HIGH, 32'd0);
                        write_reg(odtc_pkg::REG_HALF_STEP, 32'd0);
                    end
                    2: begin
                        write_reg(odtc_pkg::REG_COARSE_START, 32'd4095);
                        write_reg(odtc_pkg::REG_QUIET_LIMIT, 32'hFFFF_FFFF);
                        write_reg(odtc_pkg::REG_BACKOFF_RELOAD, 32'd1023);
                        write_reg(odtc_pkg::REG_FINE_GAIN, 32'd1023);
                        write_reg(odtc_pkg::REG_FINE_LOW, 32'd4095);
                        write_reg(odtc_pkg::REG_FINE_HIGH, 32'd4095);
                        write_reg(odtc_pkg::REG_HALF_STEP, 32'd4095);
                    end
                    default: begin
                        write_reg(odtc_pkg::REG_COARSE_START, $urandom_range(0, 4095));
                        write_reg(odtc_pkg::REG_QUIET_LIMIT, $urandom_range(0, 600));
                        write_reg(odtc_pkg::REG_BACKOFF_RELOAD, $urandom_range(0, 12));
                        write_reg(odtc_pkg::REG_FINE_GAIN, $urandom());
                        write_reg(odtc_pkg::REG_FINE_LOW, $urandom_range(0, 1500));
                        write_reg(odtc_pkg::REG_FINE_HIGH, $urandom_range(2500, 4095));
                        write_reg(odtc_pkg::REG_HALF_STEP, $urandom());
                    end
                endcase
            end
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                if (n % 16 == 0) steady_flow = ($urandom_range(0, 3) == 0);
                // error: mostly fine-mode sized, some coarse, a few anywhere
                r = $urandom_range(0, 99);
                if (r < 45)
                    p.err = odtc_pkg::ERR_W'(int'($urandom_range(0, 6)) - 3);
                else if (r < 70)
                    p.err = odtc_pkg::ERR_W'(int'($urandom_range(0, 40)) - 20);
                else if (r < 85)
                    p.err = odtc_pkg::ERR_W'(int'($urandom_range(0, 1200)) - 600);
                else if (r < 95)
                    p.err = odtc_pkg::ERR_W'($urandom());
                else
                    p.err = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                // time: short hops, hops past the table, or far jumps
                r = $urandom_range(0, 99);
                if (r < 45)      stamp_s = stamp_s + $urandom_range(0, 20);
                else if (r < 75) stamp_s = stamp_s + $urandom_range(240, 400);
                else if (r < 90) stamp_s = stamp_s + $urandom_range(0, 700);
                else             stamp_s = $urandom();
                p.stamp  = stamp_s;
                p.pinned = 1'b0;
                p.want   = '0;
                send_beat(p);
            end
        end

        // Drain
        @(negedge aclk);
        s_valid     = 1'b0;
        steady_flow = 1'b0;
        while (dac_expect_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d input beats and %0d results: %0d coarse corrections, %0d fine moves,",
                 beats_in, beats_out, coarse_fixes, fine_moves);
        $display("%0d counter reset requests, %0d register writes over %0d settings, %0d mismatches",
                 counter_resets, reg_writes, PHASES, mismatches);
        if (mismatches == 0 && dac_expect_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
